// File: rtl/core/assert_macros.svh
// Assertion helpers; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define HCA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition never holds.
`define HCA_NEVER(label, cond, msg) \
  `HCA_ASSERT(label, !(cond), msg)

`endif

// File: rtl/core/hca_pkg.sv
`default_nettype none
package hca_pkg;

  localparam int NUM_HANDLES_DEF = 64;
  localparam int ALLOC_SCAN_MAX  = 64;

  localparam int MODE_W    = 3;
  localparam int HANDLE_W  = 6;
  localparam int SIZE_W    = 24;
  localparam int ADDR_W    = 32;
  localparam int WORDS_W   = 23;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 176;
  localparam int OUT_PAD_W  = 2;

  localparam logic [ADDR_W-1:0] POOL_BASE_RST  = '0;
  localparam logic [SIZE_W-1:0] POOL_BYTES_RST = 24'd1024000;

  // Round-to-even mask on a size that has grown by one bit.
  localparam logic [SIZE_W:0] EVEN_MASK = 25'h1FF_FFFE;

  typedef enum logic [MODE_W-1:0] {
    MODE_REINIT = 3'd0,
    MODE_ALLOC  = 3'd1,
    MODE_FREE   = 3'd2,
    MODE_RESIZE = 3'd3,
    MODE_QUERY  = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_HANDLE  = 2'd1,
    ST_BAD_HANDLE = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE  = 1'b0,
    CFG_POOL_BYTES = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_EVAL,
    S_DECIDE,
    S_SHIFT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// File: rtl/core/hca_ram.sv
`default_nettype none
module hca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/handle_compacting_allocator_top.sv
`default_nettype none
`include "assert_macros.svh"
// Handle-based compacting allocator. Each request (reinit, allocate, free,
// resize, query) returns one result with the handle's start and size and,
// where blocks shift, one move command (and for allocate a clear command)
// for an external mover. Start and size of every handle live in one
// single-port-write RAM with a registered read. Allocate scans handles
// from 1 at one per cycle, stopping below min(NUM_HANDLES,64); allocate,
// resize and free then rewrite each handle above the changed one when its
// size changes. After reset and on every reinit a clearing pass writes
// all NUM_HANDLES entries, one per cycle, and no request is taken
// meanwhile. The result sits in an output register, so the next request
// is accepted while an earlier result waits.
module handle_compacting_allocator_top #(
  parameter int NUM_HANDLES = hca_pkg::NUM_HANDLES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [hca_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [hca_pkg::ADDR_W-1:0]    cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // mode[2:0], handle[8:3], request_size[32:9], zero[39:33]
  input  wire logic [hca_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // status[1:0], result_handle[7:2], block_start[39:8], block_size[63:40],
  // move_src[95:64], move_dst[127:96], move_words[150:128],
  // clear_words[173:151], zero[175:174]
  output logic [hca_pkg::OUT_DATA_W-1:0]     out_tdata
);

  import hca_pkg::*;

  localparam int IDX_W    = $clog2(NUM_HANDLES);
  localparam int CNT_W    = $clog2(NUM_HANDLES + 1);
  localparam int SCAN_LIM = (NUM_HANDLES < ALLOC_SCAN_MAX) ? NUM_HANDLES : ALLOC_SCAN_MAX;
  localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(NUM_HANDLES);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_HANDLES - 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(SCAN_LIM);

  // Request fields
  logic [MODE_W-1:0]   in_mode;
  logic [HANDLE_W-1:0] in_handle;
  logic [SIZE_W-1:0]   in_req;
  logic [SIZE_W:0]     in_rnd;
  logic                in_bad;
  logic                in_acc;

  assign in_mode   = in_tdata[2:0];
  assign in_handle = in_tdata[8:3];
  assign in_req    = in_tdata[32:9];
  assign in_rnd    = ({1'b0, in_req} + 25'd1) & EVEN_MASK;
  assign in_bad    = (in_handle == '0) || (32'(in_handle) >= 32'(NUM_HANDLES));

  // Registers
  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   pool_base_r, pool_base_nxt;
  logic [SIZE_W-1:0]   pool_bytes_r, pool_bytes_nxt;
  logic [ADDR_W-1:0]   end_r, end_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                pnd_r, pnd_nxt;
  logic [IDX_W-1:0]    pnd_idx_r, pnd_idx_nxt;
  logic                emit_r, emit_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [HANDLE_W-1:0] hin_r, hin_nxt;
  logic [IDX_W-1:0]    h_idx_r, h_idx_nxt;
  logic [SIZE_W:0]     new_size_r, new_size_nxt;
  logic [ADDR_W-1:0]   ent_start_r, ent_start_nxt;
  logic [SIZE_W-1:0]   ent_size_r, ent_size_nxt;
  logic [SIZE_W+1:0]   diff_r, diff_nxt;
  logic                grow_r, grow_nxt;
  logic [ADDR_W-1:0]   src_r, src_nxt;
  logic [ADDR_W-1:0]   used_r, used_nxt;
  logic [ADDR_W-1:0]   mod_r, mod_nxt;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  logic [ADDR_W-1:0]   res_start_r, res_start_nxt;
  logic [SIZE_W-1:0]   res_size_r, res_size_nxt;
  logic [ADDR_W-1:0]   res_src_r, res_src_nxt;
  logic [ADDR_W-1:0]   res_dst_r, res_dst_nxt;
  logic [WORDS_W-1:0]  res_words_r, res_words_nxt;
  logic [WORDS_W-1:0]  res_clear_r, res_clear_nxt;

  // RAM port
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_ent;
  entry_t             wr_ent;

  assign rd_ent    = entry_t'(ram_rdata);
  assign ram_wdata = ENTRY_W'(wr_ent);

  hca_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_HANDLES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Scan, shift and decision terms
  logic               scan_issue;
  logic               scan_found;
  logic               shift_issue;
  logic               out_free;
  logic [ADDR_W-1:0]  mod_w;
  logic [ADDR_W:0]    total_w;
  logic               over_w;
  logic               same_w;
  logic               move_w;
  logic [ADDR_W-1:0]  tail_w;
  logic [WORDS_W-1:0] words_w;
  logic               last_h;

  assign in_tready   = (state_r == S_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign scan_issue  = cnt_r < SCAN_END;
  assign scan_found  = pnd_r && (rd_ent.size == '0);
  assign shift_issue = cnt_r < N_CNT;
  assign out_free    = !out_valid_r || out_tready;
  assign mod_w       = {{(ADDR_W-SIZE_W-2){diff_r[SIZE_W+1]}}, diff_r};
  assign total_w     = {1'b0, used_r} + (ADDR_W+1)'(diff_r[SIZE_W:0]);
  assign over_w      = grow_r && (new_size_r[SIZE_W] ||
                                  (total_w > (ADDR_W+1)'(pool_bytes_r)));
  assign same_w      = (diff_r == '0);
  assign move_w      = end_r > src_r;
  assign tail_w      = end_r - src_r;
  assign words_w     = (tail_w[ADDR_W-1:WORDS_W+1] != '0) ? '1 : tail_w[WORDS_W:1];
  assign last_h      = (CNT_W'(h_idx_r) == LAST_IDX);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = emit_r ? S_RESULT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_REINIT) begin
            state_nxt = S_CLEAR;
          end else if (in_mode == MODE_ALLOC) begin
            state_nxt = S_SCAN;
          end else if (in_bad) begin
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_SCAN: begin
        if (scan_found) begin
          state_nxt = S_EVAL;
        end else if (!pnd_r && !scan_issue) begin
          state_nxt = S_RESULT;
        end
      end
      S_FETCH: begin
        if (mode_r inside {MODE_FREE, MODE_RESIZE}) begin
          state_nxt = S_EVAL;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_EVAL: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (over_w || same_w || last_h) begin
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!shift_issue) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    pool_base_nxt  = pool_base_r;
    pool_bytes_nxt = pool_bytes_r;
    end_nxt        = end_r;
    cnt_nxt        = cnt_r;
    pnd_nxt        = pnd_r;
    pnd_idx_nxt    = pnd_idx_r;
    emit_nxt       = emit_r;
    mode_nxt       = mode_r;
    hin_nxt        = hin_r;
    h_idx_nxt      = h_idx_r;
    new_size_nxt   = new_size_r;
    ent_start_nxt  = ent_start_r;
    ent_size_nxt   = ent_size_r;
    diff_nxt       = diff_r;
    grow_nxt       = grow_r;
    src_nxt        = src_r;
    used_nxt       = used_r;
    mod_nxt        = mod_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_start_nxt  = res_start_r;
    res_size_nxt   = res_size_r;
    res_src_nxt    = res_src_r;
    res_dst_nxt    = res_dst_r;
    res_words_nxt  = res_words_r;
    res_clear_nxt  = res_clear_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    ram_we         = 1'b0;
    ram_waddr      = h_idx_r;
    ram_raddr      = cnt_r[IDX_W-1:0];
    wr_ent         = '{start: ent_start_r, size: new_size_r[SIZE_W-1:0]};

    if (cfg_we) begin
      case (cfg_addr)
        CFG_POOL_BASE:  pool_base_nxt  = cfg_wdata;
        CFG_POOL_BYTES: pool_bytes_nxt = cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        // end pointer still holds the base the tables restart from
        ram_we    = 1'b1;
        ram_waddr = cnt_r[IDX_W-1:0];
        wr_ent    = '{start: end_r, size: '0};
        cnt_nxt   = cnt_r + 1'b1;
      end
      S_IDLE: begin
        ram_raddr = IDX_W'(in_handle);
        if (in_acc) begin
          mode_nxt       = in_mode;
          hin_nxt        = in_handle;
          h_idx_nxt      = IDX_W'(in_handle);
          new_size_nxt   = (in_mode == MODE_FREE) ? '0 : in_rnd;
          res_status_nxt = ST_OK;
          res_handle_nxt = '0;
          res_start_nxt  = '0;
          res_size_nxt   = '0;
          res_src_nxt    = '0;
          res_dst_nxt    = '0;
          res_words_nxt  = '0;
          res_clear_nxt  = '0;
          pnd_nxt        = 1'b0;
          if (in_mode == MODE_REINIT) begin
            end_nxt       = pool_base_r;
            res_start_nxt = pool_base_r;
            cnt_nxt       = '0;
            emit_nxt      = 1'b1;
          end else if (in_mode == MODE_ALLOC) begin
            cnt_nxt = CNT_W'(1);
          end else if (in_bad) begin
            res_status_nxt = ST_BAD_HANDLE;
            res_handle_nxt = in_handle;
          end
        end
      end
      S_SCAN: begin
        if (scan_found) begin
          h_idx_nxt      = pnd_idx_r;
          res_handle_nxt = HANDLE_W'(pnd_idx_r);
          ent_start_nxt  = rd_ent.start;
          ent_size_nxt   = rd_ent.size;
        end else if (!pnd_r && !scan_issue) begin
          res_status_nxt = ST_NO_HANDLE;
        end else begin
          pnd_nxt     = scan_issue;
          pnd_idx_nxt = cnt_r[IDX_W-1:0];
          if (scan_issue) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_FETCH: begin
        ent_start_nxt  = rd_ent.start;
        ent_size_nxt   = rd_ent.size;
        res_handle_nxt = hin_r;
        res_start_nxt  = rd_ent.start;
        res_size_nxt   = rd_ent.size;
      end
      S_EVAL: begin
        diff_nxt = {1'b0, new_size_r} - {2'b0, ent_size_r};
        grow_nxt = new_size_r > {1'b0, ent_size_r};
        src_nxt  = ent_start_r + ADDR_W'(ent_size_r);
        used_nxt = end_r - pool_base_r;
      end
      S_DECIDE: begin
        res_start_nxt = ent_start_r;
        if (over_w) begin
          res_status_nxt = ST_OVERFLOW;
          res_size_nxt   = ent_size_r;
        end else if (same_w) begin
          res_size_nxt = ent_size_r;
          if (mode_r == MODE_ALLOC) begin
            res_clear_nxt = ent_size_r[WORDS_W:1];
          end
        end else begin
          ram_we       = 1'b1;
          end_nxt      = end_r + mod_w;
          mod_nxt      = mod_w;
          res_size_nxt = new_size_r[SIZE_W-1:0];
          if (mode_r == MODE_ALLOC) begin
            res_clear_nxt = new_size_r[WORDS_W:1];
          end
          if (move_w) begin
            res_src_nxt   = src_r;
            res_dst_nxt   = src_r + mod_w;
            res_words_nxt = words_w;
          end
          cnt_nxt = CNT_W'(h_idx_r) + 1'b1;
          pnd_nxt = 1'b0;
        end
      end
      S_SHIFT: begin
        // read ahead one entry, write back the one read last cycle
        pnd_nxt     = shift_issue;
        pnd_idx_nxt = cnt_r[IDX_W-1:0];
        if (shift_issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (pnd_r) begin
          ram_we    = 1'b1;
          ram_waddr = pnd_idx_r;
          wr_ent    = '{start: rd_ent.start + mod_r, size: rd_ent.size};
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          emit_nxt      = 1'b0;
          out_data_nxt  = {{OUT_PAD_W{1'b0}}, res_clear_r, res_words_r, res_dst_r,
                           res_src_r, res_size_r, res_start_r, res_handle_r,
                           res_status_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      pool_base_r  <= POOL_BASE_RST;
      pool_bytes_r <= POOL_BYTES_RST;
      end_r        <= POOL_BASE_RST;
      cnt_r        <= '0;
      pnd_r        <= 1'b0;
      emit_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pool_base_r  <= pool_base_nxt;
      pool_bytes_r <= pool_bytes_nxt;
      end_r        <= end_nxt;
      cnt_r        <= cnt_nxt;
      pnd_r        <= pnd_nxt;
      emit_r       <= emit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pnd_idx_r    <= pnd_idx_nxt;
    mode_r       <= mode_nxt;
    hin_r        <= hin_nxt;
    h_idx_r      <= h_idx_nxt;
    new_size_r   <= new_size_nxt;
    ent_start_r  <= ent_start_nxt;
    ent_size_r   <= ent_size_nxt;
    diff_r       <= diff_nxt;
    grow_r       <= grow_nxt;
    src_r        <= src_nxt;
    used_r       <= used_nxt;
    mod_r        <= mod_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_start_r  <= res_start_nxt;
    res_size_r   <= res_size_nxt;
    res_src_r    <= res_src_nxt;
    res_dst_r    <= res_dst_nxt;
    res_words_r  <= res_words_nxt;
    res_clear_r  <= res_clear_nxt;
    out_data_r   <= out_data_nxt;
  end

  `HCA_ASSERT(a_accept_leaves_idle, in_acc |=> (state_r != S_IDLE), "request accepted but block stayed idle")
  `HCA_ASSERT(a_end_hold, (state_r != S_IDLE && state_r != S_DECIDE) |=> $stable(end_r), "end pointer moved outside an update")
  `HCA_ASSERT(a_shift_above, (state_r == S_SHIFT && ram_we) |-> (CNT_W'(ram_waddr) > CNT_W'(h_idx_r)), "shift wrote at or below the resized handle")
  `HCA_NEVER(a_clear_on_fail, (state_r == S_RESULT) && (res_status_r != ST_OK) && (res_clear_r != '0), "clear command on a failed request")

endmodule
`default_nettype wire
